FILE: rtl/core/ps2_mouse_packet_cursor_tracker_assert.svh
// Assertion macros shared by the cursor tracker RTL.
// Both macros sample on clock and are disabled while reset is high.
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PS2MCT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cursor tracker check failed");

// Consequent must hold in the cycle after the antecedent
`define PS2MCT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cursor tracker check failed");

`endif

FILE: rtl/core/ps2mct_pkg.sv
// Package for the PS/2 mouse packet cursor tracker.
// Packet slot type, protocol byte constants and register indexes; no dependencies.
package ps2mct_pkg;

   // Position of the next byte within a three-byte packet
   typedef enum logic [2:0] {
      SLOT_FLAGS = 3'b001,
      SLOT_DX    = 3'b010,
      SLOT_DY    = 3'b100
   } slot_type;

   localparam logic [7:0] ACK_BYTE = 8'hFA;
   localparam logic [7:0] OVF_MASK = 8'hC0;

   // Flag bit positions in the first packet byte
   localparam int FLAG_X_SIGN = 4;
   localparam int FLAG_Y_SIGN = 5;

   // Sign-extended delta, wide enough to carry a negated 9-bit value
   localparam int DELTA_BITS = 10;

   // Configuration port
   localparam int          CSR_INDEX_BITS = 4;
   localparam int          CSR_DATA_BITS  = 13;
   localparam logic [3:0]  CSR_SCREEN_WIDTH  = 4'd0;
   localparam logic [3:0]  CSR_SCREEN_HEIGHT = 4'd1;

   // Reset screen size
   localparam int WIDTH_RESET  = 1024;
   localparam int HEIGHT_RESET = 768;

endpackage

FILE: rtl/core/ps2mct_cursor_axis.sv
// One cursor axis: adds a signed delta and clamps to 0..limit.
// Depends on ps2mct_pkg for the delta width.
module ps2mct_cursor_axis #(
   parameter int COORD_BITS = 12
) (
   input  logic [COORD_BITS-1:0]                    cur,
   input  logic signed [ps2mct_pkg::DELTA_BITS-1:0] delta,
   input  logic [COORD_BITS-1:0]                    limit,
   output logic [COORD_BITS-1:0]                    next
);

   localparam int SUM_BITS = COORD_BITS + 2;

   logic signed [SUM_BITS-1:0] sum;

   // Two guard bits: one for the carry above the range, one for the sign
   assign sum = $signed({2'b00, cur})
              + SUM_BITS'(delta);

   // Clamp below at zero and above at the limit
   always_comb begin
      if (sum[SUM_BITS-1]) begin
         next = '0;
      end else if (sum[COORD_BITS:0] > {1'b0, limit}) begin
         next = limit;
      end else begin
         next = sum[COORD_BITS-1:0];
      end
   end

endmodule

FILE: rtl/core/ps2_mouse_packet_cursor_tracker.sv
// PS/2 mouse packet decoder with an absolute, saturating cursor. Received
// bytes enter on the req_ channel one beat at a time; acknowledge bytes (0xFA)
// are dropped anywhere. Every third remaining byte completes a packet, and a
// packet without overflow moves the cursor and gives one rsp_ beat with the
// cursor and buttons. The block takes one byte per cycle while req_stall is
// low: a byte lands in an input register, and is decoded and applied to the
// cursor once the update stage takes it; its result then stands in the output
// register until taken on the rsp_ channel. The update stage holds while an
// undelivered result is stalled. Screen size is written on the csr_ port; the
// clamp limit is worked out at the write.
// Depends on ps2mct_pkg, ps2mct_cursor_axis and the assertion macro header.
`include "ps2_mouse_packet_cursor_tracker_assert.svh"

module ps2_mouse_packet_cursor_tracker #(
   parameter int COORD_BITS = 12
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // byte input channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [7:0]                              req_rx_byte,
   // cursor result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [COORD_BITS-1:0]                   rsp_pos_x,
   output logic [COORD_BITS-1:0]                   rsp_pos_y,
   output logic [2:0]                              rsp_buttons,
   // configuration writes
   input  logic                                    csr_we,
   input  logic [ps2mct_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ps2mct_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int LIM_W       = (COORD_BITS > ps2mct_pkg::CSR_DATA_BITS) ?
                                COORD_BITS : ps2mct_pkg::CSR_DATA_BITS;
   localparam int COL_LIM_RST = (ps2mct_pkg::WIDTH_RESET - 1 > COORD_MAX) ?
                                COORD_MAX : ps2mct_pkg::WIDTH_RESET - 1;
   localparam int ROW_LIM_RST = (ps2mct_pkg::HEIGHT_RESET - 1 > COORD_MAX) ?
                                COORD_MAX : ps2mct_pkg::HEIGHT_RESET - 1;
   localparam int COL_RST     = (ps2mct_pkg::WIDTH_RESET / 2 > COORD_MAX) ?
                                COORD_MAX : ps2mct_pkg::WIDTH_RESET / 2;
   localparam int ROW_RST     = (ps2mct_pkg::HEIGHT_RESET / 2 > COORD_MAX) ?
                                COORD_MAX : ps2mct_pkg::HEIGHT_RESET / 2;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff,  in_byte_in;
   // packet state
   ps2mct_pkg::slot_type  slot_ff,     slot_in;
   logic [7:0]            flags_ff,    flags_in;
   logic [7:0]            dx_ff,       dx_in;
   // cursor and output register
   logic [COORD_BITS-1:0] col_ff,      col_in;
   logic [COORD_BITS-1:0] row_ff,      row_in;
   logic [2:0]            buttons_ff,  buttons_in;
   logic                  out_valid_ff, out_valid_in;
   // clamp limits
   logic [COORD_BITS-1:0] col_lim_ff,  col_lim_in;
   logic [COORD_BITS-1:0] row_lim_ff,  row_lim_in;

   logic                  fire;
   logic                  is_ack;
   logic                  complete;
   logic                  overflow;
   logic                  emit;
   logic [ps2mct_pkg::CSR_DATA_BITS-1:0] lim_raw;
   logic [LIM_W-1:0]      lim_wide;
   logic [COORD_BITS-1:0] lim_new;
   logic signed [ps2mct_pkg::DELTA_BITS-1:0] delta_x;
   logic signed [ps2mct_pkg::DELTA_BITS-1:0] delta_y;
   logic signed [ps2mct_pkg::DELTA_BITS-1:0] delta_y_neg;
   logic [COORD_BITS-1:0] col_next;
   logic [COORD_BITS-1:0] row_next;

   // update stage advances unless a result is waiting and stalled
   assign fire      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;

   assign rsp_valid   = out_valid_ff;
   assign rsp_pos_x   = col_ff;
   assign rsp_pos_y   = row_ff;
   assign rsp_buttons = buttons_ff;

   // input register: load on accept, empty once the update stage takes it
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // packet slot decode
   assign is_ack   = (in_byte_ff == ps2mct_pkg::ACK_BYTE);
   assign overflow = ((flags_ff & ps2mct_pkg::OVF_MASK) != 8'h00);

   always_comb begin
      complete = 1'b0;
      slot_in  = slot_ff;
      flags_in = flags_ff;
      dx_in    = dx_ff;
      if (fire && !is_ack) begin
         case (slot_ff)
            ps2mct_pkg::SLOT_FLAGS: begin
               flags_in = in_byte_ff;
               slot_in  = ps2mct_pkg::SLOT_DX;
            end
            ps2mct_pkg::SLOT_DX: begin
               dx_in   = in_byte_ff;
               slot_in = ps2mct_pkg::SLOT_DY;
            end
            ps2mct_pkg::SLOT_DY: begin
               complete = 1'b1;
               slot_in  = ps2mct_pkg::SLOT_FLAGS;
            end
            default: begin
               complete = 1'b1;
               slot_in  = ps2mct_pkg::SLOT_FLAGS;
            end
         endcase
      end
   end

   assign emit = complete && !overflow;

   // 9-bit signed deltas; y is negated because screen rows run downwards
   assign delta_x = ps2mct_pkg::DELTA_BITS'($signed({flags_ff[ps2mct_pkg::FLAG_X_SIGN], dx_ff}));
   assign delta_y = ps2mct_pkg::DELTA_BITS'($signed({flags_ff[ps2mct_pkg::FLAG_Y_SIGN],
                                                     in_byte_ff}));
   assign delta_y_neg = -delta_y;

   ps2mct_cursor_axis #(
      .COORD_BITS (COORD_BITS)
   ) u_axis_x (
      .cur   (col_ff),
      .delta (delta_x),
      .limit (col_lim_ff),
      .next  (col_next)
   );

   ps2mct_cursor_axis #(
      .COORD_BITS (COORD_BITS)
   ) u_axis_y (
      .cur   (row_ff),
      .delta (delta_y_neg),
      .limit (row_lim_ff),
      .next  (row_next)
   );

   // cursor and result register
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      buttons_in   = buttons_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         col_in       = col_next;
         row_in       = row_next;
         buttons_in   = flags_ff[2:0];
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // clamp limit from a written size: zero acts as one, cap at the top code
   assign lim_raw  = (csr_wdata == '0) ? '0 : csr_wdata - 1'b1;
   assign lim_wide = LIM_W'(lim_raw);
   assign lim_new  = (lim_wide > LIM_W'(COORD_MAX)) ? COORD_BITS'(COORD_MAX)
                                                    : COORD_BITS'(lim_wide);

   always_comb begin
      col_lim_in = col_lim_ff;
      row_lim_in = row_lim_ff;
      if (csr_we) begin
         case (csr_index)
            ps2mct_pkg::CSR_SCREEN_WIDTH:  col_lim_in = lim_new;
            ps2mct_pkg::CSR_SCREEN_HEIGHT: row_lim_in = lim_new;
            default: ;
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         slot_ff      <= ps2mct_pkg::SLOT_FLAGS;
         flags_ff     <= '0;
         dx_ff        <= '0;
         col_ff       <= COORD_BITS'(COL_RST);
         row_ff       <= COORD_BITS'(ROW_RST);
         out_valid_ff <= 1'b0;
         col_lim_ff   <= COORD_BITS'(COL_LIM_RST);
         row_lim_ff   <= COORD_BITS'(ROW_LIM_RST);
      end else begin
         in_valid_ff  <= in_valid_in;
         slot_ff      <= slot_in;
         flags_ff     <= flags_in;
         dx_ff        <= dx_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
         col_lim_ff   <= col_lim_in;
         row_lim_ff   <= row_lim_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      buttons_ff <= buttons_in;
   end

   // checks
   `PS2MCT_ASSERT_SAME(a_stall_only_when_full, !in_valid_ff, !req_stall)
   `PS2MCT_ASSERT_NEXT(a_packet_gives_result,
      fire && !is_ack && slot_ff == ps2mct_pkg::SLOT_DY && !overflow, rsp_valid)
   `PS2MCT_ASSERT_NEXT(a_dx_then_dy,
      fire && !is_ack && slot_ff == ps2mct_pkg::SLOT_DX,
      slot_ff == ps2mct_pkg::SLOT_DY)

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for ps2_mouse_packet_cursor_tracker: mouse byte streams in,
// cursor beats checked against an in-bench cursor tracker with random stalls.
// Depends on ps2mct_pkg and the tracker RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS   = 12;
   localparam int COORD_TOP    = (1 << COORD_BITS) - 1;
   localparam int SIGN_SPAN    = 256;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_PCT     = 25;

   typedef struct packed {
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic [2:0]            btn;
   } cursor_beat_type;

   logic                                    clock;
   logic                                    reset       = 1'b1;
   logic                                    req_valid   = 1'b0;
   logic                                    req_stall;
   logic [7:0]                              req_rx_byte = 8'h00;
   logic                                    rsp_valid;
   logic                                    rsp_stall   = 1'b0;
   logic [COORD_BITS-1:0]                   rsp_pos_x;
   logic [COORD_BITS-1:0]                   rsp_pos_y;
   logic [2:0]                              rsp_buttons;
   logic                                    csr_we      = 1'b0;
   logic [ps2mct_pkg::CSR_INDEX_BITS-1:0]   csr_index   = '0;
   logic [ps2mct_pkg::CSR_DATA_BITS-1:0]    csr_wdata   = '0;

   // stimulus and expected cursor beats
   logic [7:0]      mouse_bytes[$];
   cursor_beat_type pending_cursor[$];
   int              gen_slot;

   // tracker state mirrored in the bench
   logic [ps2mct_pkg::CSR_DATA_BITS-1:0] trk_width;
   logic [ps2mct_pkg::CSR_DATA_BITS-1:0] trk_height;
   ps2mct_pkg::slot_type                 trk_slot;
   logic [7:0]                           trk_flags;
   logic [7:0]                           trk_dx;
   int                                   trk_col;
   int                                   trk_row;

   // run control and statistics
   logic calm      = 1'b0;
   logic hold_kick = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left = 0;
   int   cycle_count = 0;
   int   err_count = 0;
   int   bytes_taken = 0;
   int   acks_taken = 0;
   int   beats_checked = 0;
   int   settings_done = 0;

   ps2_mouse_packet_cursor_tracker #(.COORD_BITS(COORD_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_buttons (rsp_buttons),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- cursor tracker
   // zero size acts as one; anything beyond the coordinate range pins at the top
   function automatic int axis_limit(input logic [ps2mct_pkg::CSR_DATA_BITS-1:0] size);
      int lim;
      if (size == 0) begin
         lim = 0;
      end else begin
         lim = int'(size) - 1;
      end
      if (lim > COORD_TOP) lim = COORD_TOP;
      return lim;
   endfunction

   function automatic int clamp_axis(input int v, input int lim);
      if (v < 0) return 0;
      if (v > lim) return lim;
      return v;
   endfunction

   task automatic reset_tracker();
      trk_width  = ps2mct_pkg::CSR_DATA_BITS'(ps2mct_pkg::WIDTH_RESET);
      trk_height = ps2mct_pkg::CSR_DATA_BITS'(ps2mct_pkg::HEIGHT_RESET);
      trk_slot   = ps2mct_pkg::SLOT_FLAGS;
      trk_flags  = 8'h00;
      trk_dx     = 8'h00;
      trk_col    = clamp_axis(ps2mct_pkg::WIDTH_RESET / 2, COORD_TOP);
      trk_row    = clamp_axis(ps2mct_pkg::HEIGHT_RESET / 2, COORD_TOP);
   endtask

   // one accepted byte; a completed clean packet queues the expected beat
   task automatic apply_mouse_byte(input logic [7:0] b);
      int              dx;
      int              dy;
      cursor_beat_type beat;
      if (b == ps2mct_pkg::ACK_BYTE) return;
      case (trk_slot)
         ps2mct_pkg::SLOT_FLAGS: begin
            trk_flags = b;
            trk_slot  = ps2mct_pkg::SLOT_DX;
         end
         ps2mct_pkg::SLOT_DX: begin
            trk_dx   = b;
            trk_slot = ps2mct_pkg::SLOT_DY;
         end
         default: begin
            trk_slot = ps2mct_pkg::SLOT_FLAGS;
            if ((trk_flags & ps2mct_pkg::OVF_MASK) == 8'h00) begin
               dx = int'(trk_dx) - (trk_flags[ps2mct_pkg::FLAG_X_SIGN] ? SIGN_SPAN : 0);
               dy = int'(b) - (trk_flags[ps2mct_pkg::FLAG_Y_SIGN] ? SIGN_SPAN : 0);
               // Y counts upward on the mouse, rows count downward
               trk_col = clamp_axis(trk_col + dx, axis_limit(trk_width));
               trk_row = clamp_axis(trk_row - dy, axis_limit(trk_height));
               beat.col = trk_col[COORD_BITS-1:0];
               beat.row = trk_row[COORD_BITS-1:0];
               beat.btn = trk_flags[2:0];
               pending_cursor.push_back(beat);
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic check_cursor_beat();
      cursor_beat_type want;
      if (pending_cursor.size() == 0) begin
         report_mismatch($sformatf("unexpected beat x=%0d y=%0d buttons=%0d",
                                   rsp_pos_x, rsp_pos_y, rsp_buttons));
         return;
      end
      want = pending_cursor.pop_front();
      beats_checked++;
      if (rsp_pos_x !== want.col)
         report_mismatch($sformatf("beat %0d pos_x got %0d want %0d",
                                   beats_checked, rsp_pos_x, want.col));
      if (rsp_pos_y !== want.row)
         report_mismatch($sformatf("beat %0d pos_y got %0d want %0d",
                                   beats_checked, rsp_pos_y, want.row));
      if (rsp_buttons !== want.btn)
         report_mismatch($sformatf("beat %0d buttons got %0d want %0d",
                                   beats_checked, rsp_buttons, want.btn));
   endtask

   // ---------------------------------------------------------------- byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_mouse_byte(req_rx_byte);
            bytes_taken++;
            if (req_rx_byte == ps2mct_pkg::ACK_BYTE) acks_taken++;
         end
         // payload only moves once the current beat has gone
         if (!req_valid || !req_stall) begin
            if (mouse_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid   <= 1'b1;
               req_rx_byte <= mouse_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_cursor_beat();
         rsp_stall <= (hold_left != 0) || (!calm && $urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // long output hold so the tracker backs up onto its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_kick && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus helpers
   function automatic logic [7:0] data_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == ps2mct_pkg::ACK_BYTE);
      return b;
   endfunction

   task automatic push_byte(input logic [7:0] b);
      mouse_bytes.push_back(b);
      if (b != ps2mct_pkg::ACK_BYTE) gen_slot = (gen_slot + 1) % 3;
   endtask

   task automatic push_packet(input logic [7:0] flags, input logic [7:0] dx,
                              input logic [7:0] dy, input int ack_pct);
      if ($urandom_range(0, 99) < ack_pct) push_byte(ps2mct_pkg::ACK_BYTE);
      push_byte(flags);
      if ($urandom_range(0, 99) < ack_pct) push_byte(ps2mct_pkg::ACK_BYTE);
      push_byte(dx);
      if ($urandom_range(0, 99) < ack_pct) push_byte(ps2mct_pkg::ACK_BYTE);
      push_byte(dy);
   endtask

   // random packets with a drift bias per axis, plus the odd broken sequence
   task automatic push_random_packets(input int count, input int bias_x, input int bias_y);
      logic [7:0] flags;
      logic [7:0] dx;
      logic [7:0] dy;
      int         n;
      for (int i = 0; i < count; i++) begin
         flags = data_byte();
         flags[7:6] = ($urandom_range(0, 99) < 8) ? 2'($urandom_range(1, 3)) : 2'b00;
         flags[ps2mct_pkg::FLAG_X_SIGN] = ($urandom_range(0, 99) < bias_x);
         flags[ps2mct_pkg::FLAG_Y_SIGN] = ($urandom_range(0, 99) < bias_y);
         if (flags == ps2mct_pkg::ACK_BYTE) flags[0] = 1'b1;
         dx = data_byte();
         dy = data_byte();
         if ($urandom_range(0, 3) == 0) dx = flags[ps2mct_pkg::FLAG_X_SIGN] ? 8'hFF : 8'h01;
         if ($urandom_range(0, 3) == 0) dy = flags[ps2mct_pkg::FLAG_Y_SIGN] ? 8'h00 : 8'h00;
         push_packet(flags, dx, dy, 5);
         // framing noise: stray bytes, then pad back onto a packet boundary
         if ($urandom_range(0, 99) < 10) begin
            n = $urandom_range(1, 4);
            repeat (n) push_byte(8'($urandom));
            while (gen_slot != 0) push_byte(data_byte());
         end
      end
   endtask

   task automatic csr_write(input logic [ps2mct_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [ps2mct_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == ps2mct_pkg::CSR_SCREEN_WIDTH) begin
         trk_width = data;
      end else if (idx == ps2mct_pkg::CSR_SCREEN_HEIGHT) begin
         trk_height = data;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sender holds until every expected beat is back and the pipe has drained
   task automatic wait_idle();
      do @(negedge clock);
      while (mouse_bytes.size() != 0 || req_valid || pending_cursor.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_setting(input int w, input int h, input int packets,
                              input int bias_x, input int bias_y, input logic kick);
      wait_idle();
      csr_write(ps2mct_pkg::CSR_SCREEN_WIDTH, ps2mct_pkg::CSR_DATA_BITS'(w));
      csr_write(ps2mct_pkg::CSR_SCREEN_HEIGHT, ps2mct_pkg::CSR_DATA_BITS'(h));
      // unused indexes must leave both sizes alone
      csr_write(ps2mct_pkg::CSR_INDEX_BITS'($urandom_range(2,
                   (1 << ps2mct_pkg::CSR_INDEX_BITS) - 1)),
                ps2mct_pkg::CSR_DATA_BITS'($urandom));
      settings_done++;
      @(negedge clock);
      push_random_packets(packets, bias_x, bias_y);
      if (kick) hold_kick = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      reset_tracker();
      gen_slot = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset screen, zero move, acks in every slot, sign extremes,
      // bit 3 set, overflow on either axis, full positive move
      push_packet(8'h00, 8'h00, 8'h00, 0);
      push_byte(ps2mct_pkg::ACK_BYTE);
      push_byte(8'h07);
      push_byte(ps2mct_pkg::ACK_BYTE);
      push_byte(8'h7F);
      push_byte(ps2mct_pkg::ACK_BYTE);
      push_byte(8'h80);
      push_packet(8'h38, 8'h00, 8'h00, 0);
      push_packet(8'hC0, 8'hFF, 8'hFF, 0);
      push_packet(8'h5F, 8'h01, 8'h01, 0);
      push_packet(8'hA0, 8'h10, 8'h10, 0);
      push_packet(8'h01, 8'hFF, 8'h7F, 0);

      // screen settings, extremes first; oversize then shrink clamps on the next packet
      run_setting(1, 1, 18, 50, 50, 1'b0);
      run_setting(4096, 4096, 18, 80, 20, 1'b0);
      run_setting(0, 0, 18, 50, 50, 1'b0);
      run_setting(8191, 8191, 50, 90, 10, 1'b1);
      run_setting(4097, 2, 18, 20, 80, 1'b0);
      run_setting(16, 4095, 18, 50, 50, 1'b0);
      wait_idle();
      calm = 1'b1;
      run_setting($urandom_range(1, 4096), $urandom_range(1, 4096), 18, 50, 50, 1'b0);
      wait_idle();
      calm = 1'b0;
      run_setting($urandom_range(0, 8191), $urandom_range(0, 8191), 18, 30, 70, 1'b0);
      run_setting($urandom_range(1, 300), $urandom_range(1, 300), 18, 70, 30, 1'b0);
      run_setting(1024, 768, 18, 50, 50, 1'b0);
      wait_idle();

      $display("Ran %0d bytes (%0d acknowledges), checked %0d cursor beats over %0d settings",
               bytes_taken, acks_taken, beats_checked, settings_done);
      $display("with edge saturation, overflow packets, framing noise and a %0d-cycle hold",
               HOLD_CYCLES);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
